@@ sv/oifq_pkg.sv @@
// Shared types and constants for the ordered-insert FIFO queue.
// No dependencies; every other file of the block refers to it by scoped names.

package oifq_pkg;

    // default number of entries the queue holds
    localparam int QUEUE_DEPTH_DEF = 64;

    // width of the reported occupancy field
    localparam int OCC_W = 7;

    // key / data word width
    localparam int WORD_W = 32;

    // operation codes carried in the action field
    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_ROTATE = 2'd3
    } act_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // one stored entry: ordering key plus two data words
    typedef struct packed {
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
    } entry_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REM_TAKE,
        S_INS_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_ROT_WR,
        S_RES_RD,
        S_RES_TAKE,
        S_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic in_ready;       // input channel may hand over an item
        logic rd_head;        // read entry at head slot
        logic rd_next;        // read entry after scan pointer, advance pointer
        logic rd_prev;        // read entry before shift destination
        logic wr_tail_item;   // write item at tail, count up
        logic wr_front_item;  // write item before head, move head back, count up
        logic scan_init;      // start scan from head entry just read
        logic scan_adv;       // remember entry just read as previous key
        logic shift_init_hit; // insert position is the entry just read
        logic shift_init_end; // insert position is the tail
        logic shift_wr;       // move entry just read one slot back
        logic place;          // write item at shift destination, count up
        logic rot_wr;         // copy head entry to tail, advance head
        logic pop;            // take entry just read as result, advance head, count down
        logic take_shown;     // take entry just read as result
        logic clear_shown;    // result words are zero
        logic set_empty;      // status: queue empty
        logic set_full;       // status: queue full
        logic load_out;       // move result into output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_valid;
        act_t action;
        logic empty;
        logic full;
        logic multi;
        logic head_le;
        logic hit;
        logic scan_last;
        logic shift_done;
        logic out_free;
    } stat_t;

endpackage

@@ sv/oifq_op_if.sv @@
// Operation channel of the ordered-insert FIFO queue: handshake plus one item.
// Uses oifq_pkg for the word width.

interface oifq_op_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          action;
    logic signed [oifq_pkg::WORD_W-1:0]  entry_key;
    logic signed [oifq_pkg::WORD_W-1:0]  entry_a;
    logic signed [oifq_pkg::WORD_W-1:0]  entry_b;

    modport source (output valid, output action, output entry_key, output entry_a,
                    output entry_b, input ready);
    modport sink   (input valid, input action, input entry_key, input entry_a,
                    input entry_b, output ready);
endinterface

@@ sv/oifq_res_if.sv @@
// Result channel of the ordered-insert FIFO queue: handshake plus one item.
// Uses oifq_pkg for widths.

interface oifq_res_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [oifq_pkg::WORD_W-1:0]  front_key;
    logic signed [oifq_pkg::WORD_W-1:0]  front_a;
    logic signed [oifq_pkg::WORD_W-1:0]  front_b;
    logic [oifq_pkg::OCC_W-1:0]          occupancy;

    modport source (output valid, output status, output front_key, output front_a,
                    output front_b, output occupancy, input ready);
    modport sink   (input valid, input status, input front_key, input front_a,
                    input front_b, input occupancy, output ready);
endinterface

@@ sv/oifq_ctrl.sv @@
// Sequencer of the ordered-insert FIFO queue: one state machine that steps
// the datapath through each operation. Uses oifq_pkg (state, command, status types).

module oifq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  oifq_pkg::stat_t  st,
    output oifq_pkg::cmd_t   cmd
);

    oifq_pkg::state_t state_reg;
    oifq_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oifq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            oifq_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.in_valid)
                begin
                    state_next = oifq_pkg::S_DECODE;
                end
            end

            oifq_pkg::S_DECODE:
            begin
                case (st.action)
                    oifq_pkg::ACT_APPEND:
                    begin
                        if (st.full)
                        begin
                            cmd.set_full = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_tail_item = 1'b1;
                        end
                        state_next = oifq_pkg::S_RES_RD;
                    end
                    oifq_pkg::ACT_REMOVE:
                    begin
                        if (st.empty)
                        begin
                            cmd.set_empty   = 1'b1;
                            cmd.clear_shown = 1'b1;
                            state_next      = oifq_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = oifq_pkg::S_REM_TAKE;
                        end
                    end
                    oifq_pkg::ACT_INSERT:
                    begin
                        if (st.full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = oifq_pkg::S_RES_RD;
                        end
                        else if (st.empty)
                        begin
                            cmd.wr_front_item = 1'b1;
                            state_next        = oifq_pkg::S_RES_RD;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = oifq_pkg::S_INS_CHK;
                        end
                    end
                    oifq_pkg::ACT_ROTATE:
                    begin
                        if (st.multi)
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = oifq_pkg::S_ROT_WR;
                        end
                        else
                        begin
                            state_next = oifq_pkg::S_RES_RD;
                        end
                    end
                    default:
                    begin
                        state_next = oifq_pkg::S_RES_RD;
                    end
                endcase
            end

            oifq_pkg::S_REM_TAKE:
            begin
                cmd.pop    = 1'b1;
                state_next = oifq_pkg::S_DONE;
            end

            // head entry is in the read register
            oifq_pkg::S_INS_CHK:
            begin
                if (!st.head_le)
                begin
                    cmd.wr_front_item = 1'b1;
                    state_next        = oifq_pkg::S_RES_RD;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    if (st.multi)
                    begin
                        state_next = oifq_pkg::S_SCAN_RD;
                    end
                    else
                    begin
                        cmd.shift_init_end = 1'b1;
                        state_next         = oifq_pkg::S_SHIFT_RD;
                    end
                end
            end

            oifq_pkg::S_SCAN_RD:
            begin
                cmd.rd_next = 1'b1;
                state_next  = oifq_pkg::S_SCAN_CHK;
            end

            oifq_pkg::S_SCAN_CHK:
            begin
                if (st.hit)
                begin
                    cmd.shift_init_hit = 1'b1;
                    state_next         = oifq_pkg::S_SHIFT_RD;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    if (st.scan_last)
                    begin
                        cmd.shift_init_end = 1'b1;
                        state_next         = oifq_pkg::S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = oifq_pkg::S_SCAN_RD;
                    end
                end
            end

            oifq_pkg::S_SHIFT_RD:
            begin
                if (st.shift_done)
                begin
                    state_next = oifq_pkg::S_PLACE;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = oifq_pkg::S_SHIFT_WR;
                end
            end

            oifq_pkg::S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = oifq_pkg::S_SHIFT_RD;
            end

            oifq_pkg::S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = oifq_pkg::S_RES_RD;
            end

            oifq_pkg::S_ROT_WR:
            begin
                cmd.rot_wr = 1'b1;
                state_next = oifq_pkg::S_RES_RD;
            end

            // fetch the head after the operation
            oifq_pkg::S_RES_RD:
            begin
                if (st.empty)
                begin
                    cmd.clear_shown = 1'b1;
                    state_next      = oifq_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = oifq_pkg::S_RES_TAKE;
                end
            end

            oifq_pkg::S_RES_TAKE:
            begin
                cmd.take_shown = 1'b1;
                state_next     = oifq_pkg::S_DONE;
            end

            oifq_pkg::S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = oifq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = oifq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/oifq_dpath.sv @@
// Datapath of the ordered-insert FIFO queue: entry memory, head and count,
// scan and shift pointers, result and output registers. Uses oifq_pkg and the channel interfaces.

module oifq_dpath #(
    parameter int QUEUE_DEPTH = oifq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    oifq_op_if.sink           op,
    oifq_res_if.source        res,
    input  oifq_pkg::cmd_t    cmd,
    output oifq_pkg::stat_t   st
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X   = (AW+1)'(QUEUE_DEPTH);

    // entry memory, one access per cycle
    oifq_pkg::entry_t mem [QUEUE_DEPTH];
    oifq_pkg::entry_t rdata_reg;

    // queue state
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;

    // current item
    oifq_pkg::act_t   action_reg;
    oifq_pkg::entry_t item_reg;

    // scan and shift bookkeeping
    logic signed [oifq_pkg::WORD_W-1:0] prev_key_reg;
    logic [AW-1:0] ptr_reg;
    logic [CW-1:0] idx_reg;
    logic [AW-1:0] dst_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] pos_reg;

    // result being built
    oifq_pkg::status_t status_reg;
    oifq_pkg::entry_t  shown_reg;

    // output register
    logic                        out_valid_reg;
    oifq_pkg::status_t           out_status_reg;
    oifq_pkg::entry_t            out_entry_reg;
    logic [oifq_pkg::OCC_W-1:0]  out_occ_reg;

    logic             take;
    logic [AW:0]      tail_sum;
    logic [AW-1:0]    tail_slot;
    logic [AW-1:0]    head_inc;
    logic [AW-1:0]    head_dec;
    logic [AW-1:0]    ptr_inc;
    logic [AW-1:0]    dst_dec;
    logic             we;
    logic             re;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    oifq_pkg::entry_t wdata;

    // slot arithmetic with wrap at the queue depth
    always_comb
    begin
        tail_sum  = (AW+1)'(head_reg) + (AW+1)'(count_reg);
        tail_slot = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);
        head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
        head_dec  = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
        ptr_inc   = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + AW'(1);
        dst_dec   = (dst_reg == '0) ? LAST_SLOT : dst_reg - AW'(1);
    end

    assign take     = op.valid & cmd.in_ready;
    assign op.ready = cmd.in_ready;

    // memory port select
    always_comb
    begin
        we    = cmd.wr_tail_item | cmd.wr_front_item | cmd.shift_wr | cmd.place
                | cmd.rot_wr;
        re    = cmd.rd_head | cmd.rd_next | cmd.rd_prev;
        waddr = dst_reg;
        wdata = item_reg;
        if (cmd.wr_tail_item)
        begin
            waddr = tail_slot;
        end
        else if (cmd.wr_front_item)
        begin
            waddr = head_dec;
        end
        else if (cmd.rot_wr)
        begin
            waddr = tail_slot;
            wdata = rdata_reg;
        end
        else if (cmd.shift_wr)
        begin
            wdata = rdata_reg;
        end
        raddr = head_reg;
        if (cmd.rd_next)
        begin
            raddr = ptr_inc;
        end
        else if (cmd.rd_prev)
        begin
            raddr = dst_dec;
        end
    end

    // entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // head slot and entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.wr_front_item)
            begin
                head_reg <= head_dec;
            end
            else if (cmd.rot_wr || cmd.pop)
            begin
                head_reg <= head_inc;
            end
            if (cmd.wr_tail_item || cmd.wr_front_item || cmd.place)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // item capture, scan and shift walkers, result words
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg   <= oifq_pkg::act_t'(op.action);
            item_reg.key <= op.entry_key;
            item_reg.a   <= op.entry_a;
            item_reg.b   <= op.entry_b;
            status_reg   <= oifq_pkg::STAT_DONE;
        end
        if (cmd.set_empty)
        begin
            status_reg <= oifq_pkg::STAT_EMPTY;
        end
        if (cmd.set_full)
        begin
            status_reg <= oifq_pkg::STAT_FULL;
        end
        if (cmd.scan_init)
        begin
            prev_key_reg <= rdata_reg.key;
            ptr_reg      <= head_reg;
            idx_reg      <= '0;
        end
        if (cmd.rd_next)
        begin
            ptr_reg <= ptr_inc;
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.scan_adv)
        begin
            prev_key_reg <= rdata_reg.key;
        end
        if (cmd.shift_init_hit || cmd.shift_init_end)
        begin
            dst_reg <= tail_slot;
            j_reg   <= count_reg;
            pos_reg <= cmd.shift_init_hit ? idx_reg : count_reg;
        end
        if (cmd.shift_wr)
        begin
            dst_reg <= dst_dec;
            j_reg   <= j_reg - CW'(1);
        end
        if (cmd.pop || cmd.take_shown)
        begin
            shown_reg <= rdata_reg;
        end
        if (cmd.clear_shown)
        begin
            shown_reg <= '0;
        end
    end

    // output register, free when empty or being taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_entry_reg  <= shown_reg;
            out_occ_reg    <= oifq_pkg::OCC_W'(count_reg);
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.status    = out_status_reg;
    assign res.front_key = out_entry_reg.key;
    assign res.front_a   = out_entry_reg.a;
    assign res.front_b   = out_entry_reg.b;
    assign res.occupancy = out_occ_reg;

    // status towards the controller
    always_comb
    begin
        st.in_valid   = op.valid;
        st.action     = action_reg;
        st.empty      = (count_reg == '0);
        st.full       = (count_reg == CW'(QUEUE_DEPTH));
        st.multi      = (count_reg > CW'(1));
        st.head_le    = (rdata_reg.key <= item_reg.key);
        st.hit        = (prev_key_reg <= item_reg.key) && (item_reg.key <= rdata_reg.key);
        st.scan_last  = ((idx_reg + CW'(1)) == count_reg);
        st.shift_done = (j_reg == pos_reg);
        st.out_free   = !out_valid_reg || res.ready;
    end

endmodule

@@ sv/ordered_insert_fifo_queue_unit.sv @@
// Ordered-insert FIFO queue of three-word entries (signed key plus two data words),
// one operation per item and one result item per operation: append, remove front,
// ordered insert by key, rotate front to tail. Items are taken one at a time; the
// entries live in a memory of QUEUE_DEPTH entries with a registered read, and the
// sequencer issues one memory access at a time. Ordered insert puts an item whose key
// is below the head key in front of the head; otherwise it scans the held entries for
// the insert position p, moves the later entries back one slot and writes the item at
// p. Any operation takes longer while the output register still holds a result item
// that has not been accepted.
// A finished result waits in an output register while the next item is taken in.
// Depends on oifq_pkg, oifq_op_if, oifq_res_if, oifq_ctrl and oifq_dpath.

module ordered_insert_fifo_queue_unit #(
    parameter int QUEUE_DEPTH = oifq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    oifq_op_if.sink     op,
    oifq_res_if.source  res
);

    oifq_pkg::cmd_t  cmd;
    oifq_pkg::stat_t st;

    // sequencer
    oifq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // memory, pointers and result path
    oifq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .res   (res),
        .cmd   (cmd),
        .st    (st)
    );

endmodule
